### hdl/otarx_pkg.sv
package otarx_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 32;
    localparam int COUNT_W = 20;
    localparam int PART_W  = 24;
    localparam int FILL_W  = 2;

    typedef logic [1:0]         t_cmd;
    typedef logic [1:0]         t_status;
    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [COUNT_W-1:0] t_count;

    // Command codes
    localparam t_cmd CMD_START  = 2'd0;
    localparam t_cmd CMD_HEADER = 2'd1;
    localparam t_cmd CMD_DATA   = 2'd2;
    localparam t_cmd CMD_COMMIT = 2'd3;

    // Status codes
    localparam t_status STATUS_BUSY = 2'd0;
    localparam t_status STATUS_OK   = 2'd1;
    localparam t_status STATUS_FAIL = 2'd2;

    // Configuration register indexes
    localparam logic CFG_IMAGE_SIZE   = 1'b0;
    localparam logic CFG_EXPECTED_CRC = 1'b1;

    localparam t_word CRC_INIT = 32'hFFFF_FFFF;
    localparam t_word CRC_POLY = 32'h04C1_1DB7;
    localparam t_word CRC_MSB  = 32'h8000_0000;

    // Largest image accepted at start; image_size is clamped to it.
    localparam logic [24:0] MAX_IMAGE_BYTES = 25'd524288;

    typedef struct packed {
        t_cmd                cmd;
        logic [BYTE_W-1:0]   packet_length;
        logic [BYTE_W-1:0]   data_byte;
        logic                write_ok;
    } t_item;

    typedef struct packed {
        t_status status;
        t_count  bytes_left;
        t_word   crc_value;
    } t_result;

    // Column i holds the 32-shift CRC image of a word with only bit i set.
    typedef logic [WORD_W-1:0][WORD_W-1:0] t_crc_mat;

    function automatic t_crc_mat f_crc_mat();
        t_crc_mat m;
        t_word    c;
        for (int i = 0; i < WORD_W; i++) begin
            c = t_word'(1) << i;
            for (int s = 0; s < WORD_W; s++) begin
                if ((c & CRC_MSB) != '0) begin
                    c = (c << 1) ^ CRC_POLY;
                end else begin
                    c = c << 1;
                end
            end
            m[i] = c;
        end
        return m;
    endfunction

    localparam t_crc_mat CRC_MAT = f_crc_mat();

endpackage

### hdl/otarx_crc32.sv
module otarx_crc32 (
    input  otarx_pkg::t_word i_crc,
    input  otarx_pkg::t_word i_word,
    output otarx_pkg::t_word o_crc
);

    otarx_pkg::t_word x;

    // XOR in the word, then apply the fixed 32-shift network column by column.
    always_comb begin
        x     = i_crc ^ i_word;
        o_crc = '0;
        for (int i = 0; i < otarx_pkg::WORD_W; i++) begin
            if (x[i]) begin
                o_crc = o_crc ^ otarx_pkg::CRC_MAT[i];
            end
        end
    end

endmodule

### hdl/otarx_core.sv
module otarx_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_index,
    input  otarx_pkg::t_word         i_cfg_data,
    input  logic                     i_fire,
    input  otarx_pkg::t_item         i_item,
    output logic                     o_has_result,
    output otarx_pkg::t_result       o_result
);

    localparam int BW = otarx_pkg::BYTE_W;
    localparam int PW = otarx_pkg::PART_W;
    localparam int FW = otarx_pkg::FILL_W;

    otarx_pkg::t_count r_image_size;
    otarx_pkg::t_word  r_expected_crc;

    otarx_pkg::t_count r_remaining, n_remaining;
    otarx_pkg::t_word  r_crc, n_crc;
    logic [PW-1:0]     r_part, n_part;
    logic [FW-1:0]     r_fill, n_fill;
    otarx_pkg::t_word  r_saved_crc, n_saved_crc;
    logic [PW-1:0]     r_saved_part, n_saved_part;
    logic [FW-1:0]     r_saved_fill, n_saved_fill;
    logic [BW-1:0]     r_open_len, n_open_len;
    logic [BW-1:0]     r_open_seen, n_open_seen;
    logic              r_open, n_open;

    otarx_pkg::t_word  word_crc;
    otarx_pkg::t_count start_count;
    otarx_pkg::t_count plen_ext;
    otarx_pkg::t_status status;

    otarx_crc32 u_crc32 (
        .i_crc  (r_crc),
        .i_word ({i_item.data_byte, r_part}),
        .o_crc  (word_crc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size   <= '0;
            r_expected_crc <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                otarx_pkg::CFG_IMAGE_SIZE:   r_image_size   <= i_cfg_data[otarx_pkg::COUNT_W-1:0];
                otarx_pkg::CFG_EXPECTED_CRC: r_expected_crc <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign start_count = ({5'b0, r_image_size} > otarx_pkg::MAX_IMAGE_BYTES)
                       ? otarx_pkg::MAX_IMAGE_BYTES[otarx_pkg::COUNT_W-1:0]
                       : r_image_size;
    assign plen_ext    = otarx_pkg::t_count'(i_item.packet_length);

    always_comb begin
        n_remaining  = r_remaining;
        n_crc        = r_crc;
        n_part       = r_part;
        n_fill       = r_fill;
        n_saved_crc  = r_saved_crc;
        n_saved_part = r_saved_part;
        n_saved_fill = r_saved_fill;
        n_open_len   = r_open_len;
        n_open_seen  = r_open_seen;
        n_open       = r_open;
        status       = otarx_pkg::STATUS_BUSY;

        case (i_item.cmd)
            otarx_pkg::CMD_DATA: begin
                if (r_open && (r_open_seen < r_open_len)) begin
                    if (r_fill == 2'd3) begin
                        n_crc  = word_crc;
                        n_part = '0;
                        n_fill = '0;
                    end else begin
                        n_part = r_part | (PW'(i_item.data_byte) << {r_fill, 3'b000});
                        n_fill = r_fill + 2'd1;
                    end
                    n_open_seen = r_open_seen + 8'd1;
                end
            end
            otarx_pkg::CMD_START: begin
                n_remaining  = start_count;
                n_crc        = otarx_pkg::CRC_INIT;
                n_part       = '0;
                n_fill       = '0;
                n_saved_crc  = otarx_pkg::CRC_INIT;
                n_saved_part = '0;
                n_saved_fill = '0;
                n_open_len   = '0;
                n_open_seen  = '0;
                n_open       = 1'b0;
            end
            otarx_pkg::CMD_HEADER: begin
                // Drop an open packet before taking the new header.
                if (r_open) begin
                    n_crc  = r_saved_crc;
                    n_part = r_saved_part;
                    n_fill = r_saved_fill;
                    n_open = 1'b0;
                end
                if (plen_ext > r_remaining) begin
                    n_remaining = '0;
                    status      = otarx_pkg::STATUS_FAIL;
                end else begin
                    n_saved_crc  = n_crc;
                    n_saved_part = n_part;
                    n_saved_fill = n_fill;
                    n_open_len   = i_item.packet_length;
                    n_open_seen  = '0;
                    n_open       = 1'b1;
                end
            end
            otarx_pkg::CMD_COMMIT: begin
                if (!r_open) begin
                    status = otarx_pkg::STATUS_FAIL;
                end else if (!i_item.write_ok || (r_open_seen != r_open_len)) begin
                    n_crc  = r_saved_crc;
                    n_part = r_saved_part;
                    n_fill = r_saved_fill;
                    n_open = 1'b0;
                    status = otarx_pkg::STATUS_FAIL;
                end else begin
                    n_open = 1'b0;
                    if (otarx_pkg::t_count'(r_open_len) > r_remaining) begin
                        n_remaining = '0;
                    end else begin
                        n_remaining = r_remaining - otarx_pkg::t_count'(r_open_len);
                    end
                    if (n_remaining == '0) begin
                        status = (r_crc == r_expected_crc) ? otarx_pkg::STATUS_OK
                                                           : otarx_pkg::STATUS_FAIL;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_has_result        = (i_item.cmd != otarx_pkg::CMD_DATA);
    assign o_result.status     = status;
    assign o_result.bytes_left = n_remaining;
    assign o_result.crc_value  = n_open ? n_saved_crc : n_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining  <= '0;
            r_crc        <= otarx_pkg::CRC_INIT;
            r_part       <= '0;
            r_fill       <= '0;
            r_saved_crc  <= otarx_pkg::CRC_INIT;
            r_saved_part <= '0;
            r_saved_fill <= '0;
            r_open_len   <= '0;
            r_open_seen  <= '0;
            r_open       <= 1'b0;
        end else if (i_fire) begin
            r_remaining  <= n_remaining;
            r_crc        <= n_crc;
            r_part       <= n_part;
            r_fill       <= n_fill;
            r_saved_crc  <= n_saved_crc;
            r_saved_part <= n_saved_part;
            r_saved_fill <= n_saved_fill;
            r_open_len   <= n_open_len;
            r_open_seen  <= n_open_seen;
            r_open       <= n_open;
        end
    end

endmodule

### hdl/ota_image_receiver_crc32_top.sv
// Firmware image receiver with a running word-wise CRC-32 check.
//
// Input channel (i_valid / o_stall): one request per cycle carries a command
// (start, packet header, data byte, commit) with its packet length, data byte
// and write_ok fields. A request is taken at a clock edge with i_valid high
// and o_stall low.
// Output channel (o_valid / i_stall): start, header and commit requests each
// give one result (status, bytes_left, crc_value); data bytes give none.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 image_size, 1 expected_crc); write only while no request is in flight.
//
// Throughput: one request per cycle while no stalled result blocks the input
// register; the update between the input register and the result register is
// combinational (the 32-shift CRC is a fixed XOR network). A request waits in
// the input register, and its result is loaded into the result register.
// Reset (synchronous, active low) empties both registers, clears the counters
// and sets the CRC to all ones. While i_stall holds a result, the input
// register keeps one more request and then raises o_stall.
module ota_image_receiver_crc32_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_packet_length,
    input  logic [7:0]  i_data_byte,
    input  logic        i_write_ok,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [19:0] o_bytes_left,
    output logic [31:0] o_crc_value
);

    logic               r_in_valid;
    otarx_pkg::t_item   r_item;
    logic               r_out_valid;
    otarx_pkg::t_result r_result;

    logic               advance;
    logic               fire;
    logic               has_result;
    otarx_pkg::t_result result;

    // Advance when the result register is empty or being drained.
    assign advance = !r_out_valid || !i_stall;
    assign fire    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;

    // Input register: load on acceptance, empty once the request is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item.cmd           <= i_cmd;
            r_item.packet_length <= i_packet_length;
            r_item.data_byte     <= i_data_byte;
            r_item.write_ok      <= i_write_ok;
        end
    end

    otarx_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_fire       (fire),
        .i_item       (r_item),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // Result register: hold while stalled, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has_result) begin
            r_result <= result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_result.status;
    assign o_bytes_left = r_result.bytes_left;
    assign o_crc_value  = r_result.crc_value;

endmodule

### hdl/otarx_checker.sv
module otarx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_status,
    input logic [19:0] o_bytes_left,
    input logic [31:0] o_crc_value
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == otarx_pkg::STATUS_BUSY ||
                     o_status == otarx_pkg::STATUS_OK ||
                     o_status == otarx_pkg::STATUS_FAIL))
        else $error("status code out of range");

    a_ok_means_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == otarx_pkg::STATUS_OK) |-> (o_bytes_left == '0))
        else $error("image reported good with bytes left");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({5'b0, o_bytes_left} <= otarx_pkg::MAX_IMAGE_BYTES))
        else $error("bytes_left above image limit");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) &&
                               $stable(o_bytes_left) && $stable(o_crc_value))
        else $error("stalled result changed");

endmodule

bind ota_image_receiver_crc32_top otarx_checker u_otarx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_bytes_left (o_bytes_left),
    .o_crc_value  (o_crc_value)
);
